FILE: hw/rtl/hs_pkg.sv
`timescale 1ns / 1ps

package hs_pkg;

  // Element width of the stream payload
  localparam int DATA_W = 32;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_TAKE,
    OP_SETUP,
    OP_BUILD_RD,
    OP_BUILD_LD,
    OP_EXT_RD,
    OP_EXT_SWAP,
    OP_SIFT,
    OP_OUT_RD,
    OP_OUT_LD
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    S_COLLECT,
    S_SETUP,
    S_BUILD_RD,
    S_BUILD_LD,
    S_BUILD_SIFT,
    S_EXT_RD,
    S_EXT_SWAP,
    S_EXT_SIFT,
    S_OUT_RD,
    S_OUT_LD
  } ctrl_state_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic in_fire;     // input transfer this cycle
    logic in_last;     // transferred item closes the set
    logic few;         // fewer than two elements stored
    logic idx_zero;    // heap build reached the root
    logic size_gt1;    // more extraction steps remain
    logic sift_done;   // sift-down settled this cycle
    logic out_free;    // output register can take a result
    logic out_last;    // result being loaded is the final one
  } stat_t;

endpackage

FILE: hw/rtl/hs_in_if.sv
`timescale 1ns / 1ps

interface hs_in_if;
  import hs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);

endinterface

FILE: hw/rtl/hs_out_if.sv
`timescale 1ns / 1ps

interface hs_out_if;
  import hs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic                     dropped;

  modport source (output valid, sorted_value, last_out, dropped, input ready);
  modport sink   (input valid, sorted_value, last_out, dropped, output ready);

endinterface

FILE: hw/rtl/hs_ram.sv
`timescale 1ns / 1ps

module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                          rdata_a,
  input  logic                                      re_b,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports that hold when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/hs_dp.sv
`timescale 1ns / 1ps

module hs_dp #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  hs_pkg::dp_op_t op,
  output hs_pkg::stat_t  stat,
  hs_in_if.sink          items,
  hs_out_if.source       results
);
  import hs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  // Control registers
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] size;
  logic [CW-1:0] idx;
  logic [AW-1:0] node;
  logic [CW-1:0] k;
  logic          out_valid;

  // Payload registers
  logic signed [DATA_W-1:0] v;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     out_dropped;

  // Memory ports
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic                     re_a;
  logic                     re_b;
  logic [AW-1:0]            raddr_a;
  logic [AW-1:0]            raddr_b;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;

  logic                     in_fire;
  logic                     has_room;
  logic                     out_free;
  logic                     k_last;
  logic [IW-1:0]            left_idx;
  logic [IW-1:0]            right_idx;
  logic                     left_ok;
  logic                     right_ok;
  logic [IW-1:0]            big_idx;
  logic signed [DATA_W-1:0] big_val;
  logic                     move;
  logic [AW-1:0]            big_node;
  logic [AW-1:0]            base_node;
  logic [IW-1:0]            base_left;
  logic [IW-1:0]            base_right;

  assign items.ready  = (op == OP_TAKE);
  assign in_fire      = items.valid && items.ready;
  assign has_room     = (count < CW'(CAPACITY));
  assign out_free     = !out_valid || results.ready;
  assign k_last       = ((k + CW'(1)) == count);

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_out     = out_last;
  assign results.dropped      = out_dropped;

  // Children of the current node against the live heap size
  assign left_idx  = IW'({node, 1'b1});
  assign right_idx = left_idx + IW'(1);
  assign left_ok   = (left_idx < IW'(size));
  assign right_ok  = (right_idx < IW'(size));

  // Pick the larger child; left wins only if strictly greater, right likewise
  always_comb begin
    big_idx = IW'(node);
    big_val = v;
    if (left_ok && (rd_a > big_val)) begin
      big_idx = left_idx;
      big_val = rd_a;
    end
    if (right_ok && (rd_b > big_val)) begin
      big_idx = right_idx;
      big_val = rd_b;
    end
  end

  assign move     = (big_idx != IW'(node));
  assign big_node = big_idx[AW-1:0];

  // Node whose children get fetched for the next sift level
  always_comb begin
    if (op == OP_EXT_SWAP) begin
      base_node = '0;
    end else if (op == OP_SIFT) begin
      base_node = big_node;
    end else begin
      base_node = node;
    end
  end

  assign base_left  = IW'({base_node, 1'b1});
  assign base_right = base_left + IW'(1);

  // Memory port steering
  always_comb begin
    we      = 1'b0;
    waddr   = count[AW-1:0];
    wdata   = items.value;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = base_left[AW-1:0];
    raddr_b = base_right[AW-1:0];
    unique case (op)
      OP_TAKE: begin
        we = in_fire && has_room;
      end
      OP_BUILD_RD: begin
        re_a    = 1'b1;
        raddr_a = AW'(idx - CW'(1));
      end
      OP_BUILD_LD: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      OP_EXT_RD: begin
        re_a    = 1'b1;
        raddr_a = '0;
        re_b    = 1'b1;
        raddr_b = AW'(size - CW'(1));
      end
      OP_EXT_SWAP: begin
        we    = 1'b1;
        waddr = AW'(size - CW'(1));
        wdata = rd_a;
        re_a  = 1'b1;
        re_b  = 1'b1;
      end
      OP_SIFT: begin
        we    = 1'b1;
        waddr = node;
        wdata = big_val;
        re_a  = move;
        re_b  = move;
      end
      OP_OUT_RD: begin
        re_a    = 1'b1;
        raddr_a = AW'(k);
      end
      default: begin
      end
    endcase
  end

  hs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  // Counters, indexes and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      size      <= '0;
      idx       <= '0;
      node      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new load keeps valid high across a transfer
      if (op == OP_OUT_LD && out_free) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_TAKE: begin
          if (in_fire) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        OP_SETUP: begin
          size <= count;
          idx  <= count >> 1;
          k    <= '0;
        end
        OP_BUILD_RD: begin
          idx  <= idx - CW'(1);
          node <= AW'(idx - CW'(1));
        end
        OP_EXT_SWAP: begin
          size <= size - CW'(1);
          node <= '0;
        end
        OP_SIFT: begin
          if (move) begin
            node <= big_node;
          end
        end
        OP_OUT_LD: begin
          if (out_free) begin
            k <= k + CW'(1);
            if (k_last) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sift value and output payload
  always_ff @(posedge clk) begin
    case (op)
      OP_BUILD_LD: v <= rd_a;
      OP_EXT_SWAP: v <= rd_b;
      OP_OUT_LD: begin
        if (out_free) begin
          out_value   <= rd_a;
          out_last    <= k_last;
          out_dropped <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  always_comb begin
    stat.in_fire   = in_fire;
    stat.in_last   = items.last;
    stat.few       = (count <= CW'(1));
    stat.idx_zero  = (idx == '0);
    stat.size_gt1  = (size > CW'(1));
    stat.sift_done = !move;
    stat.out_free  = out_free;
    stat.out_last  = k_last;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_sift_node: assert property (@(posedge clk) disable iff (rst)
    (op == OP_SIFT) |-> (IW'(node) < IW'(size)))
    else $error("sift node outside heap");

  a_swap_size: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EXT_SWAP) |-> (size > CW'(1)))
    else $error("extraction on heap of one");

endmodule

FILE: hw/rtl/hs_ctrl.sv
`timescale 1ns / 1ps

module hs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  hs_pkg::stat_t  stat,
  output hs_pkg::dp_op_t op
);
  import hs_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    unique case (state)
      S_COLLECT: begin
        op = OP_TAKE;
        if (stat.in_fire && stat.in_last) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        op = OP_SETUP;
        state_next = stat.few ? S_OUT_RD : S_BUILD_RD;
      end
      S_BUILD_RD: begin
        op = OP_BUILD_RD;
        state_next = S_BUILD_LD;
      end
      S_BUILD_LD: begin
        op = OP_BUILD_LD;
        state_next = S_BUILD_SIFT;
      end
      S_BUILD_SIFT: begin
        op = OP_SIFT;
        if (stat.sift_done) begin
          state_next = stat.idx_zero ? S_EXT_RD : S_BUILD_RD;
        end
      end
      S_EXT_RD: begin
        op = OP_EXT_RD;
        state_next = S_EXT_SWAP;
      end
      S_EXT_SWAP: begin
        op = OP_EXT_SWAP;
        state_next = S_EXT_SIFT;
      end
      S_EXT_SIFT: begin
        op = OP_SIFT;
        if (stat.sift_done) begin
          state_next = stat.size_gt1 ? S_EXT_RD : S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        op = OP_OUT_RD;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        op = OP_OUT_LD;
        if (stat.out_free) begin
          state_next = stat.out_last ? S_COLLECT : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/heap_sort.sv
`timescale 1ns / 1ps
// Loading: one item per cycle; the item marked last starts the sort of N stored values.
// Sort: heap build then N-1 extractions; each sift-down has two setup steps, one step
// per level moved and one closing step. Output: each result is a memory read, then an
// output register load that waits while the output is stalled. Synchronous active-high
// reset empties the set; stored values are not cleared.

module heap_sort #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  hs_in_if.sink     items,
  hs_out_if.source  results
);
  import hs_pkg::*;

  dp_op_t op;
  stat_t  stat;

  hs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .op   (op)
  );

  hs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .stat    (stat),
    .items   (items),
    .results (results)
  );

endmodule
